/* hw/rtl/rgb_to_yuv420_converter_defines.svh */
// Assertion macros for the RGB to YUV 4:2:0 converter.
`ifndef RGB_TO_YUV420_CONVERTER_DEFINES_SVH
`define RGB_TO_YUV420_CONVERTER_DEFINES_SVH

// cons must hold in the same cycle as ante
`define RYC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgb_to_yuv420_converter: assertion failed");

// cons must hold in the cycle after ante
`define RYC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgb_to_yuv420_converter: assertion failed");

`endif

/* hw/rtl/ryc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ryc_pkg;

  localparam int PIX_W         = 8;
  localparam int WEIGHT_W      = 8;
  localparam int LUMA_ADDR_W   = 24;
  localparam int CHROMA_ADDR_W = 22;
  localparam int CFG_DATA_W    = 13;
  localparam int CFG_IDX_W     = 3;
  localparam int IN_DATA_W     = 24;
  localparam int OUT_DATA_W    = 72;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [WEIGHT_W-1:0]   RST_LUMA_RED      = 8'd77;
  localparam logic [WEIGHT_W-1:0]   RST_LUMA_GREEN    = 8'd150;
  localparam logic [WEIGHT_W-1:0]   RST_LUMA_BLUE     = 8'd29;
  localparam logic [WEIGHT_W-1:0]   RST_U_WEIGHT      = 8'd143;
  localparam logic [WEIGHT_W-1:0]   RST_V_WEIGHT      = 8'd182;
  localparam logic [WEIGHT_W-1:0]   RST_CHROMA_OFFSET = 8'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_LUMA_RED      = 3'd1,
    REG_LUMA_GREEN    = 3'd2,
    REG_LUMA_BLUE     = 3'd3,
    REG_U_WEIGHT      = 3'd4,
    REG_V_WEIGHT      = 3'd5,
    REG_CHROMA_OFFSET = 3'd6
  } cfg_reg_t;

  // multiplier step selected by the controller
  typedef enum logic [2:0] {
    OP_NONE,
    OP_MAC_R,
    OP_MAC_G,
    OP_MAC_B,
    OP_LUMA,
    OP_CHROMA_U,
    OP_CHROMA_V
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_R,
    ST_MAC_G,
    ST_MAC_B,
    ST_LUMA,
    ST_CHROMA_U,
    ST_CHROMA_V,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;      // capture input pixel, advance position
    op_t  op;
    logic out_load;  // move finished result into output register
  } cmd_t;

  typedef struct packed {
    logic chroma_valid;
  } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/ryc_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

module ryc_controller (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire ryc_pkg::sts_t sts,
  output ryc_pkg::cmd_t    cmd
);
  import ryc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.load     = 1'b0;
    cmd.op       = OP_NONE;
    cmd.out_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MAC_R;
        end
      end
      ST_MAC_R: begin
        cmd.op    = OP_MAC_R;
        state_nxt = ST_MAC_G;
      end
      ST_MAC_G: begin
        cmd.op    = OP_MAC_G;
        state_nxt = ST_MAC_B;
      end
      ST_MAC_B: begin
        cmd.op    = OP_MAC_B;
        state_nxt = ST_LUMA;
      end
      ST_LUMA: begin
        cmd.op    = OP_LUMA;
        state_nxt = sts.chroma_valid ? ST_CHROMA_U : ST_DONE;
      end
      ST_CHROMA_U: begin
        cmd.op    = OP_CHROMA_U;
        state_nxt = ST_CHROMA_V;
      end
      ST_CHROMA_V: begin
        cmd.op    = OP_CHROMA_V;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load)              out_valid_nxt = 1'b1;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

/* hw/rtl/ryc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module ryc_datapath #(
  parameter int MAX_WIDTH            = 4096,
  parameter int WEIGHT_FRACTION_BITS = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ryc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [ryc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic [ryc_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                             in_tuser,
  input  wire ryc_pkg::cmd_t                    cmd,
  output ryc_pkg::sts_t                         sts,
  output logic [ryc_pkg::OUT_DATA_W-1:0]        out_tdata,
  output logic                                  out_tuser
);
  import ryc_pkg::*;

  localparam int F  = WEIGHT_FRACTION_BITS;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int MW = $clog2(MAX_WIDTH + 1);
  localparam int WW = (MW > CFG_DATA_W) ? MW : CFG_DATA_W;
  localparam int AW = 18;                                  // sum of three 16-bit products
  localparam int TW = ((F + 9 > 18) ? F + 9 : 18) + 1;     // chroma sum
  localparam logic [WW-1:0] MAX_WIDTH_V = WW'(MAX_WIDTH);

  // configuration
  logic [CFG_DATA_W-1:0] width_cfg_r;
  logic [WEIGHT_W-1:0]   w_red_r, w_green_r, w_blue_r, w_u_r, w_v_r, offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_cfg_r <= RST_IMAGE_WIDTH;
      w_red_r     <= RST_LUMA_RED;
      w_green_r   <= RST_LUMA_GREEN;
      w_blue_r    <= RST_LUMA_BLUE;
      w_u_r       <= RST_U_WEIGHT;
      w_v_r       <= RST_V_WEIGHT;
      offset_r    <= RST_CHROMA_OFFSET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   width_cfg_r <= cfg_wdata;
        REG_LUMA_RED:      w_red_r     <= cfg_wdata[WEIGHT_W-1:0];
        REG_LUMA_GREEN:    w_green_r   <= cfg_wdata[WEIGHT_W-1:0];
        REG_LUMA_BLUE:     w_blue_r    <= cfg_wdata[WEIGHT_W-1:0];
        REG_U_WEIGHT:      w_u_r       <= cfg_wdata[WEIGHT_W-1:0];
        REG_V_WEIGHT:      w_v_r       <= cfg_wdata[WEIGHT_W-1:0];
        REG_CHROMA_OFFSET: offset_r    <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // raster position
  logic [CW-1:0]            col_r, col_nxt, col_cur;
  logic                     odd_r, odd_nxt, odd_cur;
  logic [LUMA_ADDR_W-1:0]   lcnt_r, lcnt_nxt, laddr_cur;
  logic [CHROMA_ADDR_W-1:0] ccnt_r, ccnt_nxt, caddr_cur;
  logic [WW-1:0]            width_eff, width_ext, col_inc;
  logic                     sof, cvalid_cur;

  always_comb begin
    sof       = in_tuser;
    width_ext = WW'(width_cfg_r);
    if (width_ext == '0)               width_eff = WW'(1);
    else if (width_ext > MAX_WIDTH_V)  width_eff = MAX_WIDTH_V;
    else                               width_eff = width_ext;

    col_cur   = (sof || WW'(col_r) >= width_eff) ? '0 : col_r;
    odd_cur   = sof ? 1'b0 : odd_r;
    laddr_cur = sof ? '0 : lcnt_r;
    caddr_cur = sof ? '0 : ccnt_r;
    cvalid_cur = !odd_cur && !col_cur[0];

    col_inc  = WW'(col_cur) + WW'(1);
    lcnt_nxt = laddr_cur + LUMA_ADDR_W'(1);
    ccnt_nxt = cvalid_cur ? caddr_cur + CHROMA_ADDR_W'(1) : caddr_cur;
    if (col_inc >= width_eff) begin
      col_nxt = '0;
      odd_nxt = !odd_cur;
    end else begin
      col_nxt = col_inc[CW-1:0];
      odd_nxt = odd_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      odd_r  <= 1'b0;
      lcnt_r <= '0;
      ccnt_r <= '0;
    end else if (cmd.load) begin
      col_r  <= col_nxt;
      odd_r  <= odd_nxt;
      lcnt_r <= lcnt_nxt;
      ccnt_r <= ccnt_nxt;
    end
  end

  // current item
  logic [PIX_W-1:0]         red_r, green_r, blue_r;
  logic [LUMA_ADDR_W-1:0]   laddr_r;
  logic [CHROMA_ADDR_W-1:0] caddr_r;
  logic                     cvalid_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      red_r    <= in_tdata[7:0];
      green_r  <= in_tdata[15:8];
      blue_r   <= in_tdata[23:16];
      laddr_r  <= laddr_cur;
      caddr_r  <= caddr_cur;
      cvalid_r <= cvalid_cur;
    end
  end

  assign sts.chroma_valid = cvalid_r;

  // shared multiplier: one product per step
  logic signed [PIX_W:0]    mul_a, mul_b;
  logic signed [2*PIX_W+1:0] prod;
  logic [AW-1:0]            acc_r, acc_nxt, acc_sh;
  logic [PIX_W-1:0]         y_r, y_nxt, u_r, v_r, chroma_q;
  logic signed [TW-1:0]     t, q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MAC_R:    begin mul_a = $signed({1'b0, red_r});   mul_b = $signed({1'b0, w_red_r});   end
      OP_MAC_G:    begin mul_a = $signed({1'b0, green_r}); mul_b = $signed({1'b0, w_green_r}); end
      OP_MAC_B:    begin mul_a = $signed({1'b0, blue_r});  mul_b = $signed({1'b0, w_blue_r});  end
      OP_CHROMA_U: begin
        mul_a = $signed({1'b0, blue_r}) - $signed({1'b0, y_r});
        mul_b = $signed({1'b0, w_u_r});
      end
      OP_CHROMA_V: begin
        mul_a = $signed({1'b0, red_r}) - $signed({1'b0, y_r});
        mul_b = $signed({1'b0, w_v_r});
      end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  always_comb begin
    acc_nxt = acc_r;
    unique case (cmd.op) inside
      OP_MAC_R:           acc_nxt = {2'b00, prod[2*PIX_W-1:0]};
      OP_MAC_G, OP_MAC_B: acc_nxt = acc_r + {2'b00, prod[2*PIX_W-1:0]};
      default: ;
    endcase

    // luma: truncate then clip
    acc_sh = acc_r >> F;
    y_nxt  = (|acc_sh[AW-1:PIX_W]) ? 8'hFF : acc_sh[PIX_W-1:0];

    // chroma: floor of the sum, clipped to 0..255
    t = $signed({{(TW - 18){prod[17]}}, prod})
      + $signed({{(TW - 8 - F){1'b0}}, offset_r, {F{1'b0}}});
    q = t >>> F;
    if (t[TW-1])                 chroma_q = '0;
    else if (|q[TW-2:PIX_W])     chroma_q = 8'hFF;
    else                         chroma_q = q[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (cmd.op == OP_LUMA)     y_r <= y_nxt;
    if (cmd.op == OP_CHROMA_U) u_r <= chroma_q;
    if (cmd.op == OP_CHROMA_V) v_r <= chroma_q;
  end

  // output register; chroma fields read zero when not produced
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {2'b00,
                     cvalid_r ? caddr_r : '0,
                     cvalid_r ? v_r     : '0,
                     cvalid_r ? u_r     : '0,
                     laddr_r,
                     y_r};
      out_user_r <= cvalid_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_yuv420_converter.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  tdata (low bit up)                               tuser
// in_      in   red[7:0] green[15:8] blue[23:16]                  start_of_frame
// out_     out  luma[7:0] luma_address[31:8] u_value[39:32]       chroma_valid
//               v_value[47:40] chroma_address[69:48] zero[71:70]
// cfg_     in   write enable, register index, 13-bit write data (no read-back)
//
// One pixel in flight, stepped through the single shared 9x9 multiplier as R, G,
// B, then U and V on chroma sites (even row, even column) only.
// The output register holds one result, so the next pixel is taken while a
// result waits; a stalled output holds the block in its final step.
// rst_n is synchronous, active low: position, counts and handshake clear,
// registers return to their defaults.
`include "rgb_to_yuv420_converter_defines.svh"

module rgb_to_yuv420_converter #(
  parameter int MAX_WIDTH            = 4096,
  parameter int WEIGHT_FRACTION_BITS = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // config write port
  input  wire logic                           cfg_we,
  input  wire logic [ryc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ryc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // pixel input
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [ryc_pkg::IN_DATA_W-1:0]  in_tdata,   // red, green, blue
  input  wire logic                           in_tuser,   // start_of_frame
  // result output
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [ryc_pkg::OUT_DATA_W-1:0]      out_tdata,  // luma, luma_address, u, v,
                                                          // chroma_address, pad
  output logic                                out_tuser   // chroma_valid
);
  import ryc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: accept, three luma MACs, clip, optional U/V, hand off
  ryc_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // config registers, raster position, shared multiplier, output register
  ryc_datapath #(
    .MAX_WIDTH            (MAX_WIDTH),
    .WEIGHT_FRACTION_BITS (WEIGHT_FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // a transfer in starts a multi-cycle computation
  `RYC_ASSERT_NEXT(a_busy_after_in, in_tvalid && in_tready, !in_tready)
  // results never overwrite one still waiting
  `RYC_ASSERT_SAME(a_no_overwrite, cmd.out_load, !out_tvalid || out_tready)
  // non-chroma sites carry zero U, V and chroma address
  `RYC_ASSERT_SAME(a_chroma_zero, out_tvalid && !out_tuser, out_tdata[69:32] == '0)

endmodule

`default_nettype wire
